FILE: sv/phd_pkg.sv
// ----------------------------------------------------------------------------
// phd_pkg
// Shared types and constants for the probe health tracker.
// ----------------------------------------------------------------------------
`default_nettype none

package phd_pkg;

  localparam int SERVERS  = 64;
  localparam int ID_W     = 6;
  localparam int ADDR_W   = (SERVERS > 1) ? $clog2(SERVERS) : 1;
  localparam int LAT_W    = 20;
  localparam int FAIL_W   = 8;
  localparam int HEALTH_W = 2;
  localparam int CFG_IDX_W = 1;
  localparam int CFG_W    = 20;

  localparam logic [HEALTH_W-1:0] ST_UP       = 2'd0;
  localparam logic [HEALTH_W-1:0] ST_DEGRADED = 2'd1;
  localparam logic [HEALTH_W-1:0] ST_DOWN     = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FAIL_LIMIT = 1'd1;

  localparam logic [LAT_W-1:0]  THRESHOLD_RST  = 20'd500;
  localparam logic [FAIL_W-1:0] FAIL_LIMIT_RST = 8'd3;
  localparam logic [FAIL_W-1:0] FAIL_MAX       = 8'hFF;

  typedef struct packed {
    logic [ID_W-1:0]  server_id;
    logic             probe_ok;
    logic [LAT_W-1:0] latency_ms;
  } probe_t;

  typedef struct packed {
    logic [ID_W-1:0]     result_server;
    logic [HEALTH_W-1:0] health_state;
    logic [LAT_W-1:0]    latency_average;
    logic [FAIL_W-1:0]   fail_count;
  } result_t;

  // One server record as held in the record memory.
  typedef struct packed {
    logic                avg_valid;
    logic [LAT_W-1:0]    average;
    logic [FAIL_W-1:0]   fails;
    logic [HEALTH_W-1:0] health;
  } rec_t;

  localparam rec_t REC_RST = '{avg_valid: 1'b0, average: '0, fails: '0, health: ST_DOWN};

  // Port of the record memory seen from the update side.
  typedef struct packed {
    logic              en;
    logic [ADDR_W-1:0] addr;
    rec_t              rec;
  } wr_port_t;

endpackage

`default_nettype wire

FILE: sv/phd_store.sv
// ----------------------------------------------------------------------------
// phd_store
// Record memory with per-entry valid bits and same-entry write forwarding.
// ----------------------------------------------------------------------------
`default_nettype none

module phd_store
  import phd_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              rd_en,
  input  wire logic [ADDR_W-1:0] rd_addr,
  input  wire wr_port_t          wr,
  output rec_t                   rd_rec
);

  rec_t              mem [SERVERS];
  logic [SERVERS-1:0] valid;
  rec_t              rd_data;
  logic              rd_valid;
  logic              fwd_hit;
  rec_t              fwd_rec;

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.rec;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid    <= '0;
      rd_valid <= 1'b0;
      fwd_hit  <= 1'b0;
    end else begin
      if (wr.en) begin
        valid[wr.addr] <= 1'b1;
      end
      if (rd_en) begin
        rd_valid <= valid[rd_addr];
        // catch a write landing on the same entry at the read edge
        fwd_hit  <= wr.en && (wr.addr == rd_addr);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      fwd_rec <= wr.rec;
    end
  end

  always_comb begin
    if (fwd_hit) begin
      rd_rec = fwd_rec;
    end else if (rd_valid) begin
      rd_rec = rd_data;
    end else begin
      rd_rec = REC_RST;
    end
  end

endmodule

`default_nettype wire

FILE: sv/phd_update.sv
// ----------------------------------------------------------------------------
// phd_update
// Applies one probe result to a server record.
// ----------------------------------------------------------------------------
`default_nettype none

module phd_update
  import phd_pkg::*;
(
  input  wire probe_t            probe,
  input  wire rec_t              rec,
  input  wire logic [LAT_W-1:0]  threshold,
  input  wire logic [FAIL_W-1:0] fail_limit,
  output logic                   in_range,
  output rec_t                   rec_next,
  output result_t                res
);

  logic [LAT_W+2:0] sum;
  logic [LAT_W-1:0] avg_new;
  logic [FAIL_W-1:0] fails_new;

  always_comb begin
    in_range = (32'(probe.server_id) < SERVERS);
    // avg*7 + lat as (avg<<3) - avg + lat
    sum = {rec.average, 3'b000} - {3'b000, rec.average} + {3'b000, probe.latency_ms};
    avg_new = rec.avg_valid ? sum[LAT_W+2:3] : probe.latency_ms;
    fails_new = (rec.fails == FAIL_MAX) ? FAIL_MAX : rec.fails + FAIL_W'(1);

    rec_next = rec;
    if (probe.probe_ok) begin
      rec_next.avg_valid = 1'b1;
      rec_next.average   = avg_new;
      rec_next.fails     = '0;
      rec_next.health    = (avg_new >= threshold) ? ST_DEGRADED : ST_UP;
    end else begin
      rec_next.fails = fails_new;
      if (fails_new >= fail_limit) begin
        rec_next.health = ST_DOWN;
      end
    end

    res.result_server = probe.server_id;
    if (in_range) begin
      res.health_state    = rec_next.health;
      res.latency_average = rec_next.average;
      res.fail_count      = rec_next.fails;
    end else begin
      res.health_state    = ST_DOWN;
      res.latency_average = '0;
      res.fail_count      = '0;
    end
  end

endmodule

`default_nettype wire

FILE: sv/probe_health_tracker.sv
// ----------------------------------------------------------------------------
// probe_health_tracker
// Per-server health record (smoothed latency, fail count, state) per probe.
// ----------------------------------------------------------------------------
// Path: a transferred probe reads its record from memory, then the update writes
//   the record back and the registered result is strobed on result.
// Throughput: one probe per cycle unless busy, set by one read and one write of the
//   record memory per cycle; a write-to-read forward covers repeats of one server.
// Reset: synchronous; every server reads as down with zero average and fail
//   count, register defaults load, busy is held past release by a register. No stall.
// ----------------------------------------------------------------------------
`default_nettype none

module probe_health_tracker
  import phd_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 start,
  output logic                      busy,
  input  wire probe_t               probe,
  output logic                      result_valid,
  output result_t                   result,
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [CFG_W-1:0]     cfg_data
);

  logic [LAT_W-1:0]  threshold;
  logic [FAIL_W-1:0] fail_limit;

  logic    accept;
  logic    s1_valid;
  probe_t  s1_probe;
  rec_t    cur_rec;
  rec_t    new_rec;
  logic    in_range;
  result_t res_next;
  wr_port_t wr;

  // Hold busy through reset and the first cycle after it; the pipeline never
  // backs up.
  always_ff @(posedge clk) begin
    busy <= rst;
  end

  assign accept = start && !busy;

  // Configuration registers: the user must write them only while idle; the block itself does not enforce this.
  always_ff @(posedge clk) begin
    if (rst) begin
      threshold  <= THRESHOLD_RST;
      fail_limit <= FAIL_LIMIT_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_THRESHOLD:  threshold  <= cfg_data[LAT_W-1:0];
        REG_FAIL_LIMIT: fail_limit <= cfg_data[FAIL_W-1:0];
        default: ;
      endcase
    end
  end

  // Stage 1: capture the probe while the memory read is in flight.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_probe <= probe;
    end
  end

  phd_store u_store (
    .clk     (clk),
    .rst     (rst),
    .rd_en   (accept),
    .rd_addr (probe.server_id[ADDR_W-1:0]),
    .wr      (wr),
    .rd_rec  (cur_rec)
  );

  // Stage 2: modify the record, write it back and register the result.
  phd_update u_update (
    .probe      (s1_probe),
    .rec        (cur_rec),
    .threshold  (threshold),
    .fail_limit (fail_limit),
    .in_range   (in_range),
    .rec_next   (new_rec),
    .res        (res_next)
  );

  // Drop writes for indexes that have no record.
  assign wr = '{en:   s1_valid && in_range,
                addr: s1_probe.server_id[ADDR_W-1:0],
                rec:  new_rec};

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else begin
      result_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_valid) begin
      result <= res_next;
    end
  end

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  a_result_follows_transfer: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> $past(start && !busy, 2))
    else $error("result without a matching probe transfer");

  a_result_server: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> (result.result_server == $past(probe.server_id, 2)))
    else $error("result server does not match probe");

  a_success_clears_fails: assert property (@(posedge clk) disable iff (rst)
    (result_valid && $past(probe.probe_ok, 2)) |-> (result.fail_count == '0))
    else $error("successful probe left a nonzero fail count");

  a_state_legal: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> (result.health_state <= ST_DOWN))
    else $error("illegal health state code");

endmodule

`default_nettype wire
